/* rtl/core/dmbt_pkg.sv */
`default_nettype none

package dmbt_pkg;

    // Map geometry
    localparam int NUM_VOICES = 3;
    localparam int NUM_STEPS  = 32;
    localparam int GRID_SIDE  = 5;
    localparam int NODE_SIZE  = NUM_VOICES * NUM_STEPS;
    localparam int MAP_DEPTH  = GRID_SIDE * GRID_SIDE * NODE_SIZE;
    localparam int MAP_AW     = $clog2(MAP_DEPTH);
    localparam int STEP_W     = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
    localparam int VOICE_MAX  = NUM_VOICES - 1;

    // Accent threshold on the blended level
    localparam logic [7:0] ACCENT_LEVEL = 8'd192;

    // Request kinds
    typedef enum logic
    {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    // Corner read order of a query
    typedef enum logic [1:0]
    {
        CORNER_A = 2'd0,
        CORNER_B = 2'd1,
        CORNER_C = 2'd2,
        CORNER_D = 2'd3
    } corner_t;

    typedef logic [MAP_AW-1:0] map_addr_t;

    // Classified request as it travels from front to back
    typedef struct packed
    {
        kind_t      kind;
        logic       wr_ok;
        map_addr_t  addr;
        logic [7:0] wr_byte;
        logic [7:0] wx;
        logic [7:0] wy;
        logic [7:0] density;
    } dmbt_req_t;

    // Step modulo NUM_STEPS by restoring subtraction against the constant
    function automatic logic [STEP_W-1:0] step_wrap(input logic [7:0] s);
        logic [15:0] r;
        r = 16'(s);
        for (int k = 7; k >= 0; k--)
        begin
            if (r >= 16'(NUM_STEPS << k))
            begin
                r = r - 16'(NUM_STEPS << k);
            end
        end
        return r[STEP_W-1:0];
    endfunction

    // Voice clamped to the last voice
    function automatic logic [2:0] voice_sat(input logic [2:0] v);
        logic [2:0] vmax;
        vmax = 3'(VOICE_MAX);
        return (v > vmax) ? vmax : v;
    endfunction

    // Address of corner A for a query
    function automatic map_addr_t query_addr(input logic [2:0] v, input logic [7:0] x,
                                             input logic [7:0] y, input logic [7:0] s);
        int idx;
        idx = (int'(x[7:6]) * GRID_SIDE + int'(y[7:6])) * NODE_SIZE
              + int'(voice_sat(v)) * NUM_STEPS + int'(step_wrap(s));
        return MAP_AW'(idx);
    endfunction

    // Offset of each corner relative to corner A
    function automatic map_addr_t corner_offset(input corner_t c);
        map_addr_t offs;
        unique case (c)
            CORNER_A: offs = '0;
            CORNER_B: offs = MAP_AW'(GRID_SIDE * NODE_SIZE);
            CORNER_C: offs = MAP_AW'(NODE_SIZE);
            CORNER_D: offs = MAP_AW'((GRID_SIDE + 1) * NODE_SIZE);
            default:  offs = '0;
        endcase
        return offs;
    endfunction

    // 8-bit crossfade: (a*(255-w) + b*w) >> 8
    function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] w);
        logic [16:0] sum;
        sum = 17'(a * (8'd255 - w)) + 17'(b * w);
        return sum[15:8];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/drum_map_bilinear_trigger.sv */
// Drum map with bilinear level interpolation and trigger decision.
//
// Request channel (req_valid / req_stall): kind 0 writes map_byte at
// map_address (addresses past the end of the map are dropped) and gives
// no response; kind 1 queries the level for voice, pos_x, pos_y and
// step_number and gives exactly one response.
// Response channel (rsp_valid / rsp_stall): level_out, fire, accented.
//
// A query reads its four corner bytes through the single map port, one
// per cycle while the back end is not frozen; a write needs one access.
// The next request is taken as the current one makes its last access,
// before the current query's response has reached the output register.
// A two-entry queue sits between request decode and the map port, so
// requests keep being taken while a response waits to be collected.
//
// While rsp_stall holds a pending response, the back end freezes and the
// queue fills; req_stall rises when the queue is full. Reset empties the
// queue and pipeline; map contents are not cleared and each entry must be
// written before any query reads it.
`default_nettype none

module drum_map_bilinear_trigger
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        kind,
    input  logic [11:0] map_address,
    input  logic [7:0]  map_byte,
    input  logic [2:0]  voice,
    input  logic [7:0]  pos_x,
    input  logic [7:0]  pos_y,
    input  logic [7:0]  fill_density,
    input  logic [7:0]  step_number,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [7:0]  level_out,
    output logic        fire,
    output logic        accented
);
    import dmbt_pkg::*;

    dmbt_req_t  front_req;
    dmbt_req_t  q_entry;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    logic       push;

    assign req_stall = q_full;
    assign push      = req_valid && !q_full;

    // Request decode
    dmbt_front u_front
    (
        .kind         (kind),
        .map_address  (map_address),
        .map_byte     (map_byte),
        .voice        (voice),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .fill_density (fill_density),
        .step_number  (step_number),
        .req          (front_req)
    );

    // Decoupling queue
    dmbt_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_req),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (q_pop)
    );

    // Map access and interpolation
    dmbt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .level_out (level_out),
        .fire      (fire),
        .accented  (accented)
    );

endmodule

`default_nettype wire

/* rtl/core/dmbt_front.sv */
`default_nettype none

module dmbt_front
(
    input  logic                 kind,
    input  logic [11:0]          map_address,
    input  logic [7:0]           map_byte,
    input  logic [2:0]           voice,
    input  logic [7:0]           pos_x,
    input  logic [7:0]           pos_y,
    input  logic [7:0]           fill_density,
    input  logic [7:0]           step_number,
    output dmbt_pkg::dmbt_req_t  req
);
    import dmbt_pkg::*;

    // Classify the request and resolve its map address
    always_comb
    begin
        req.kind    = kind_t'(kind);
        req.wr_byte = map_byte;
        req.wx      = {pos_x[5:0], 2'b00};
        req.wy      = {pos_y[5:0], 2'b00};
        req.density = fill_density;
        if (kind_t'(kind) == KIND_WRITE)
        begin
            req.wr_ok = (int'(map_address) < MAP_DEPTH);
            req.addr  = MAP_AW'(map_address);
        end
        else
        begin
            req.wr_ok = 1'b0;
            req.addr  = query_addr(voice, pos_x, pos_y, step_number);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/dmbt_queue.sv */
`default_nettype none

module dmbt_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dmbt_pkg::dmbt_req_t  push_entry,
    output logic                 full,
    output logic                 q_valid,
    output dmbt_pkg::dmbt_req_t  q_entry,
    input  logic                 pop
);
    import dmbt_pkg::*;

    dmbt_req_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_entry = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/dmbt_back.sv */
`default_nettype none

module dmbt_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  dmbt_pkg::dmbt_req_t  q_entry,
    output logic                 q_pop,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [7:0]           level_out,
    output logic                 fire,
    output logic                 accented
);
    import dmbt_pkg::*;

    // Map memory, single port, registered read
    logic [7:0]  mem [MAP_DEPTH];
    logic [7:0]  rd_reg;

    // Issue stage
    logic        busy_reg;
    logic        busy_next;
    corner_t     cnt_reg;
    corner_t     cnt_next;
    dmbt_req_t   cur_reg;

    // Read-return stage
    logic        s1_valid_reg;
    corner_t     s1_corner_reg;
    logic [7:0]  s1_wx_reg;
    logic [7:0]  s1_wy_reg;
    logic [7:0]  s1_dens_reg;
    logic [7:0]  a_reg;
    logic [7:0]  c_reg;
    logic [7:0]  top_reg;

    // Final blend stage
    logic        fin_valid_reg;
    logic [7:0]  fin_top_reg;
    logic [7:0]  fin_bot_reg;
    logic [7:0]  fin_wy_reg;
    logic [7:0]  fin_dens_reg;

    // Output register
    logic        out_valid_reg;
    logic [7:0]  level_reg;
    logic        fire_reg;
    logic        accent_reg;

    logic        adv;
    logic        op_last;
    logic        take;
    logic        mem_we;
    logic        mem_re;
    map_addr_t   rd_addr;
    logic [7:0]  level_c;
    logic        fire_c;

    // Whole back end moves only when the output register can take a result
    assign adv = !out_valid_reg || !rsp_stall;

    // Issue control: a write makes one map access, a query four
    always_comb
    begin
        op_last   = busy_reg && ((cur_reg.kind == KIND_WRITE) || (cnt_reg == CORNER_D));
        take      = adv && (!busy_reg || op_last);
        q_pop     = take && q_valid;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (take)
        begin
            busy_next = q_valid;
            cnt_next  = CORNER_A;
        end
        else if (adv && busy_reg)
        begin
            cnt_next = corner_t'(cnt_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= CORNER_A;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_entry;
        end
    end

    // Memory port
    assign mem_we  = adv && busy_reg && (cur_reg.kind == KIND_WRITE) && cur_reg.wr_ok;
    assign mem_re  = adv && busy_reg && (cur_reg.kind == KIND_QUERY);
    assign rd_addr = cur_reg.addr + corner_offset(cnt_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cur_reg.addr] <= cur_reg.wr_byte;
        end
        if (mem_re)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Read-return tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= mem_re;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            s1_corner_reg <= cnt_reg;
            s1_wx_reg     <= cur_reg.wx;
            s1_wy_reg     <= cur_reg.wy;
            s1_dens_reg   <= cur_reg.density;
        end
    end

    // Corner collection and horizontal blends
    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            case (s1_corner_reg)
                CORNER_A: a_reg <= rd_reg;
                CORNER_B: top_reg <= blend8(a_reg, rd_reg, s1_wx_reg);
                CORNER_C: c_reg <= rd_reg;
                CORNER_D:
                begin
                    fin_top_reg  <= top_reg;
                    fin_bot_reg  <= blend8(c_reg, rd_reg, s1_wx_reg);
                    fin_wy_reg   <= s1_wy_reg;
                    fin_dens_reg <= s1_dens_reg;
                end
                default: a_reg <= rd_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            fin_valid_reg <= s1_valid_reg && (s1_corner_reg == CORNER_D);
        end
    end

    // Vertical blend and trigger decision
    assign level_c = blend8(fin_top_reg, fin_bot_reg, fin_wy_reg);
    assign fire_c  = level_c > ~fin_dens_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && fin_valid_reg)
        begin
            level_reg  <= level_c;
            fire_reg   <= fire_c;
            accent_reg <= fire_c && (level_c > ACCENT_LEVEL);
        end
    end

    assign rsp_valid = out_valid_reg;
    assign level_out = level_reg;
    assign fire      = fire_reg;
    assign accented  = accent_reg;

endmodule

`default_nettype wire

/* verif/tb_drum_map_bilinear_trigger.sv */
`timescale 1ns / 1ps

module tb_drum_map_bilinear_trigger;

    import dmbt_pkg::*;

    localparam int TOTAL_ITEMS  = 1450;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 24;

    // Shadow of the drum map plus the queue of levels still owed by the block
    class drum_level_scoreboard;

        typedef struct packed
        {
            logic [7:0] level;
            logic       fire;
            logic       accent;
        } level_result_t;

        logic [7:0]    map_mem [MAP_DEPTH];
        bit            loaded [MAP_DEPTH];
        level_result_t pending_levels [$];
        int            errors;
        int            writes_kept;
        int            writes_dropped;
        int            queries;
        int            fires;
        int            accents;

        function new();
            errors         = 0;
            writes_kept    = 0;
            writes_dropped = 0;
            queries        = 0;
            fires          = 0;
            accents        = 0;
        endfunction

        // Linear address of one corner byte for a query
        function int corner_addr(logic [2:0] v, logic [7:0] x, logic [7:0] y,
                                 logic [7:0] s, corner_t c);
            int vi;
            int node;
            vi   = (int'(v) > VOICE_MAX) ? VOICE_MAX : int'(v);
            node = int'(x[7:6]) * GRID_SIDE + int'(y[7:6]);
            case (c)
                CORNER_B: node += GRID_SIDE;
                CORNER_C: node += 1;
                CORNER_D: node += GRID_SIDE + 1;
                default:  ;
            endcase
            return node * NODE_SIZE + vi * NUM_STEPS + int'(s) % NUM_STEPS;
        endfunction

        function bit is_loaded(int a);
            return loaded[a];
        endfunction

        function int outstanding();
            return pending_levels.size();
        endfunction

        function int crossfade(int a, int b, int w);
            return ((a * (255 - w) + b * w) >> 8) & 255;
        endfunction

        // Accepted request: update the shadow map or queue the expected level
        function void note_request(kind_t k, logic [11:0] addr, logic [7:0] data,
                                   logic [2:0] v, logic [7:0] x, logic [7:0] y,
                                   logic [7:0] dens, logic [7:0] s);
            int            ca;
            int            cb;
            int            cc;
            int            cd;
            int            wx;
            int            wy;
            int            lvl;
            logic [7:0]    thresh;
            level_result_t r;
            if (k == KIND_WRITE)
            begin
                if (int'(addr) < MAP_DEPTH)
                begin
                    map_mem[addr] = data;
                    loaded[addr]  = 1'b1;
                    writes_kept++;
                end
                else
                begin
                    writes_dropped++;
                end
                return;
            end
            ca     = int'(map_mem[corner_addr(v, x, y, s, CORNER_A)]);
            cb     = int'(map_mem[corner_addr(v, x, y, s, CORNER_B)]);
            cc     = int'(map_mem[corner_addr(v, x, y, s, CORNER_C)]);
            cd     = int'(map_mem[corner_addr(v, x, y, s, CORNER_D)]);
            wx     = int'(x[5:0]) << 2;
            wy     = int'(y[5:0]) << 2;
            lvl    = crossfade(crossfade(ca, cb, wx), crossfade(cc, cd, wx), wy);
            thresh = ~dens;
            r.level  = 8'(lvl);
            r.fire   = lvl > int'(thresh);
            r.accent = r.fire && (lvl > int'(ACCENT_LEVEL));
            pending_levels.push_back(r);
            queries++;
            if (r.fire)
                fires++;
            if (r.accent)
                accents++;
        endfunction

        // Accepted response: compare against the oldest expected level
        function void check_response(logic [7:0] lvl, logic f, logic acc);
            level_result_t r;
            if (pending_levels.size() == 0)
            begin
                $error("response with no query pending: level_out=%0d fire=%0b accented=%0b",
                       lvl, f, acc);
                errors++;
                return;
            end
            r = pending_levels.pop_front();
            if (lvl !== r.level)
            begin
                $error("level_out: expected %0d, got %0d", r.level, lvl);
                errors++;
            end
            if (f !== r.fire)
            begin
                $error("fire: expected %0b, got %0b", r.fire, f);
                errors++;
            end
            if (acc !== r.accent)
            begin
                $error("accented: expected %0b, got %0b", r.accent, acc);
                errors++;
            end
        endfunction

    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic        kind;
    logic [11:0] map_address;
    logic [7:0]  map_byte;
    logic [2:0]  voice;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  fill_density;
    logic [7:0]  step_number;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [7:0]  level_out;
    logic        fire;
    logic        accented;

    drum_level_scoreboard sb;
    int                   items_sent;
    int                   cycles;
    bit                   quiet;

    drum_map_bilinear_trigger dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .map_address  (map_address),
        .map_byte     (map_byte),
        .voice        (voice),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .fill_density (fill_density),
        .step_number  (step_number),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .level_out    (level_out),
        .fire         (fire),
        .accented     (accented)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length: mostly none, some short, a few long; none in quiet stretches
    function automatic int idle_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'h00;
        if (r < 20)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Positions lean on the blend weight extremes
    function automatic logic [7:0] pick_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return {2'($urandom_range(0, 3)), 6'h00};
        if (r < 30)
            return {2'($urandom_range(0, 3)), 6'h3F};
        return 8'($urandom_range(0, 255));
    endfunction

    // Drive one request and hold it until the block takes it
    task automatic send_request(kind_t k, logic [11:0] addr, logic [7:0] data,
                                logic [2:0] v, logic [7:0] x, logic [7:0] y,
                                logic [7:0] dens, logic [7:0] s);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid    <= 1'b1;
        kind         <= k;
        map_address  <= addr;
        map_byte     <= data;
        voice        <= v;
        pos_x        <= x;
        pos_y        <= y;
        fill_density <= dens;
        step_number  <= s;
        do @(posedge clk); while (req_stall);
        sb.note_request(k, addr, data, v, x, y, dens, s);
        items_sent++;
    endtask

    // Write request; query fields carry noise
    task automatic send_write(logic [11:0] addr, logic [7:0] data);
        send_request(KIND_WRITE, addr, data, 3'($urandom_range(0, 7)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Query request; write fields carry noise
    task automatic send_query(logic [2:0] v, logic [7:0] x, logic [7:0] y,
                              logic [7:0] dens, logic [7:0] s);
        send_request(KIND_QUERY, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
                     v, x, y, dens, s);
    endtask

    // Load corner bytes a query will read; fresh rewrites even loaded ones
    task automatic load_corners(logic [2:0] v, logic [7:0] x, logic [7:0] y,
                                logic [7:0] s, bit fresh);
        int a;
        for (int c = 0; c < 4; c++)
        begin
            a = sb.corner_addr(v, x, y, s, corner_t'(c));
            if (fresh || !sb.is_loaded(a))
                send_write(12'(a), pick_byte());
        end
    endtask

    // Set the four corners of a query to chosen bytes
    task automatic pin_corners(logic [2:0] v, logic [7:0] x, logic [7:0] y, logic [7:0] s,
                               logic [7:0] ba, logic [7:0] bb, logic [7:0] bc,
                               logic [7:0] bd);
        send_write(12'(sb.corner_addr(v, x, y, s, CORNER_A)), ba);
        send_write(12'(sb.corner_addr(v, x, y, s, CORNER_B)), bb);
        send_write(12'(sb.corner_addr(v, x, y, s, CORNER_C)), bc);
        send_write(12'(sb.corner_addr(v, x, y, s, CORNER_D)), bd);
    endtask

    // Response side: random stalls between collected responses
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                stall_left = idle_len();
            end
        end
    end

    // Response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(level_out, fire, accented);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_drum_map_bilinear_trigger: errors");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] v;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] dens;
        logic [7:0] s;
        int         r;
        sb           = new();
        items_sent   = 0;
        cycles       = 0;
        quiet        = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        kind         = KIND_WRITE;
        map_address  = '0;
        map_byte     = '0;
        voice        = '0;
        pos_x        = '0;
        pos_y        = '0;
        fill_density = '0;
        step_number  = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: dropped writes past the end
        send_write(12'(MAP_DEPTH), 8'hAA);
        send_write(12'hFFF, 8'h55);

        // Full-scale corners at the origin, widest density: accent
        pin_corners(3'd0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_query(3'd0, 8'h00, 8'h00, 8'hFF, 8'h00);

        // Far corner of the map, voice saturated, step wrapped; density 0 then max
        pin_corners(3'd7, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
        send_query(3'd7, 8'hFF, 8'hFF, 8'h00, 8'hFF);
        send_query(3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

        // Mid cell, step exactly one wrap, mid density; then same bytes via voice 2
        pin_corners(3'd3, 8'h7F, 8'hC0, 8'd32, 8'd200, 8'd10, 8'd90, 8'd250);
        send_query(3'd3, 8'h7F, 8'hC0, 8'd128, 8'd32);
        send_query(3'd2, 8'h40, 8'hFF, 8'd200, 8'd0);

        // Random traffic: mostly loaded queries, plus map writes and noise
        while (items_sent < TOTAL_ITEMS)
        begin
            quiet = ((items_sent / 120) % 5) == 3;
            r     = $urandom_range(0, 99);
            if (r < 55 || r >= 92)
            begin
                v    = 3'($urandom_range(0, 7));
                x    = pick_pos();
                y    = pick_pos();
                dens = 8'($urandom_range(0, 255));
                s    = 8'($urandom_range(0, 255));
                // fresh corners right before the query stress write-then-read ordering
                load_corners(v, x, y, s, r >= 92);
                send_query(v, x, y, dens, s);
            end
            else if (r < 85)
            begin
                send_write(12'($urandom_range(0, MAP_DEPTH - 1)), pick_byte());
            end
            else
            begin
                send_write(12'($urandom_range(MAP_DEPTH, 4095)), pick_byte());
            end
        end
        @(negedge clk);
        req_valid <= 1'b0;

        // Drain
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d map writes kept, %0d dropped past the end",
                 items_sent, sb.writes_kept, sb.writes_dropped);
        $display("covered %0d queries: %0d fired, %0d accented",
                 sb.queries, sb.fires, sb.accents);
        if (sb.errors == 0)
        begin
            $display("tb_drum_map_bilinear_trigger: clean");
        end
        else
        begin
            $display("tb_drum_map_bilinear_trigger: errors");
        end
        $finish;
    end

endmodule
